// File: hw/rtl/aocc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aocc_pkg
// Shared widths, codes and helpers for the accelerometer offset
// calibrate/correct core.
// ----------------------------------------------------------------------------
package aocc_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 17;
    localparam int BIAS_W    = 13;
    localparam int ZOUT_W    = 14;
    localparam int CNT_W     = 5;
    localparam int ONE_G_W   = 11;

    // stream packing
    localparam int IN_DATA_W  = 6 * BYTE_W;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 2 * BIAS_W + ZOUT_W;
    localparam int OUT_USER_W = 2;

    // defaults
    localparam int                 CAL_SAMPLES_DEFAULT = 20;
    localparam logic [ONE_G_W-1:0] ONE_G_RESET         = 11'd1024;

    // operation carried on the input tuser
    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_MEASURE   = 1'b1;

    // result kind carried on the output tuser
    typedef enum logic [OUT_USER_W-1:0] {
        KIND_CORRECTED = 2'd0,
        KIND_CAL_BUSY  = 2'd1,
        KIND_CAL_DONE  = 2'd2
    } kind_t;

    // one result item
    typedef struct packed {
        logic signed [ZOUT_W-1:0] z_value;
        logic signed [BIAS_W-1:0] y_value;
        logic signed [BIAS_W-1:0] x_value;
        kind_t                    result_kind;
    } result_t;

    // data register pair to signed 12-bit sample (word shifted right by 4)
    function automatic logic signed [SAMPLE_W-1:0] decode_axis(
        input logic [BYTE_W-1:0] lo,
        input logic [BYTE_W-1:0] hi
    );
        logic [2*BYTE_W-1:0] word;
        begin
            word = {hi, lo};
            return signed'(word[2*BYTE_W-1:2*BYTE_W-SAMPLE_W]);
        end
    endfunction

endpackage

// File: hw/rtl/accel_offset_calibrate_correct_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_offset_calibrate_correct_core
// Accelerometer zero-g offset calibration and sample correction.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one reading per transfer: six axis register bytes in tdata,
//   the operation in tuser (calibrate or measure). m_* returns exactly one
//   result per reading: corrected sample, calibration busy, or new offsets.
//   cfg_* writes the counts-per-g value used to remove gravity from z; write
//   it only while no reading is in flight.
// Throughput:
//   an accepted reading's result is registered in the output register (or
//   the skid entry while the receiver stalls). One reading per cycle is
//   sustained while the receiver keeps up; sums, divide by the sample count
//   (reciprocal multiply) and offset subtract are all combinational.
// Stall:
//   results sit in an output register backed by one skid entry, so one more
//   reading is taken while the receiver stalls; s_tready drops once the skid
//   entry is full and rises as soon as the receiver takes a result.
// Reset:
//   sums, sample count and offsets clear to zero, counts-per-g goes to 1024,
//   both output entries are emptied.
// ----------------------------------------------------------------------------
module accel_offset_calibrate_correct_core #(
    parameter int CAL_SAMPLES = aocc_pkg::CAL_SAMPLES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write: one_g_counts
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aocc_pkg::ONE_G_W-1:0]    cfg_data,
    // input readings
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
    input  logic [aocc_pkg::IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [aocc_pkg::IN_USER_W-1:0]  s_tuser,
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // x_value, y_value, z_value
    output logic [aocc_pkg::OUT_DATA_W-1:0] m_tdata,
    // result_kind
    output logic [aocc_pkg::OUT_USER_W-1:0] m_tuser
);

    localparam int SAMPLE_W = aocc_pkg::SAMPLE_W;
    localparam int SUM_W    = aocc_pkg::SUM_W;
    localparam int BIAS_W   = aocc_pkg::BIAS_W;
    localparam int ZOUT_W   = aocc_pkg::ZOUT_W;
    localparam int CNT_W    = aocc_pkg::CNT_W;
    localparam int BYTE_W   = aocc_pkg::BYTE_W;

    // reciprocal for exact floor(mag / CAL_SAMPLES) over SUM_W-bit magnitudes
    localparam int              DIV_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
    localparam int              MULT_W    = SUM_W + 1;
    localparam int              PROD_W    = SUM_W + MULT_W;
    localparam longint unsigned DIV_MULT_FULL =
        ((64'd1 << DIV_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_FULL);
    localparam logic [CNT_W-1:0]  CAL_LAST = CNT_W'(CAL_SAMPLES);

    // signed sum divided by CAL_SAMPLES, truncated toward zero
    function automatic logic signed [BIAS_W-1:0] average(
        input logic signed [SUM_W-1:0] sum
    );
        logic [SUM_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quo;
        logic [BIAS_W-1:0] q;
        begin
            mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
            prod = PROD_W'(mag) * PROD_W'(DIV_MULT);
            quo  = prod >> DIV_SHIFT;
            q    = quo[BIAS_W-1:0];
            return sum[SUM_W-1] ? signed'(-q) : signed'(q);
        end
    endfunction

    // state
    logic [aocc_pkg::ONE_G_W-1:0] one_g_reg;
    logic signed [SUM_W-1:0]      sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SUM_W-1:0]      sum_x_next, sum_y_next, sum_z_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic signed [BIAS_W-1:0]     bias_x_reg, bias_y_reg, bias_z_reg;
    logic signed [BIAS_W-1:0]     bias_x_next, bias_y_next, bias_z_next;

    // output register and skid entry
    aocc_pkg::result_t out_reg, skid_reg, result;
    logic              out_valid_reg, skid_valid_reg;

    logic                      accept;
    logic                      out_take;
    logic                      is_measure;
    logic                      cal_done;
    logic signed [SAMPLE_W-1:0] sx, sy, sz;
    logic signed [BIAS_W-1:0]  avg_x, avg_y, avg_z;
    logic signed [BIAS_W-1:0]  g_ext;

    // config write is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_g_reg <= aocc_pkg::ONE_G_RESET;
        end
        else if (cfg_valid)
        begin
            one_g_reg <= cfg_data;
        end
    end

    // handshake
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_take = !out_valid_reg || m_tready;

    // decode the reading
    assign sx = aocc_pkg::decode_axis(s_tdata[0*BYTE_W +: BYTE_W], s_tdata[1*BYTE_W +: BYTE_W]);
    assign sy = aocc_pkg::decode_axis(s_tdata[2*BYTE_W +: BYTE_W], s_tdata[3*BYTE_W +: BYTE_W]);
    assign sz = aocc_pkg::decode_axis(s_tdata[4*BYTE_W +: BYTE_W], s_tdata[5*BYTE_W +: BYTE_W]);
    assign is_measure = (s_tuser[0] == aocc_pkg::OP_MEASURE);

    // accumulate and check for the end of a calibration run
    assign sum_x_next = sum_x_reg + SUM_W'(sx);
    assign sum_y_next = sum_y_reg + SUM_W'(sy);
    assign sum_z_next = sum_z_reg + SUM_W'(sz);
    assign count_next = count_reg + CNT_W'(1);
    assign cal_done   = (count_next >= CAL_LAST);

    // new offsets, gravity removed from z
    assign avg_x = average(sum_x_next);
    assign avg_y = average(sum_y_next);
    assign avg_z = average(sum_z_next);
    assign g_ext = signed'(BIAS_W'(one_g_reg));

    assign bias_x_next = avg_x;
    assign bias_y_next = avg_y;
    assign bias_z_next = (sum_z_next > 0) ? (avg_z - g_ext) : (avg_z + g_ext);

    // result of the current reading
    always_comb
    begin
        result = '0;
        if (is_measure)
        begin
            result.result_kind = aocc_pkg::KIND_CORRECTED;
            result.x_value     = BIAS_W'(sx) - bias_x_reg;
            result.y_value     = BIAS_W'(sy) - bias_y_reg;
            result.z_value     = ZOUT_W'(sz) - ZOUT_W'(bias_z_reg);
        end
        else if (cal_done)
        begin
            result.result_kind = aocc_pkg::KIND_CAL_DONE;
            result.x_value     = bias_x_next;
            result.y_value     = bias_y_next;
            result.z_value     = ZOUT_W'(bias_z_next);
        end
        else
        begin
            result.result_kind = aocc_pkg::KIND_CAL_BUSY;
        end
    end

    // calibration state update on each calibrate transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_z_reg  <= '0;
            count_reg  <= '0;
            bias_x_reg <= '0;
            bias_y_reg <= '0;
            bias_z_reg <= '0;
        end
        else if (accept && !is_measure)
        begin
            if (cal_done)
            begin
                sum_x_reg  <= '0;
                sum_y_reg  <= '0;
                sum_z_reg  <= '0;
                count_reg  <= '0;
                bias_x_reg <= bias_x_next;
                bias_y_reg <= bias_y_next;
                bias_z_reg <= bias_z_next;
            end
            else
            begin
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                sum_z_reg <= sum_z_next;
                count_reg <= count_next;
            end
        end
    end

    // output register and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.result_kind;
    assign m_tdata  = {out_reg.z_value, out_reg.y_value, out_reg.x_value};

endmodule

// File: test/tb_accel_offset_calibrate_correct_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_offset_calibrate_correct_core
// Self-checking bench for the accelerometer offset calibrate/correct core.
// A directed table covers sample extremes, measurement before, during and
// after a calibration, and a calibration whose offsets can be read off
// directly. Random phases follow, each with its own counts-per-g setting:
// mostly full calibration runs with random readings and stray measurements
// mixed in, plus measurement bursts and raw noise. Every result is checked
// field by field against an in-bench model of the sums and offsets, while
// the input side sends in bursts and the output side stalls.
// ----------------------------------------------------------------------------
module tb_accel_offset_calibrate_correct_core;

    localparam int CAL_N       = aocc_pkg::CAL_SAMPLES_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 115;

    localparam int IN_DATA_W  = aocc_pkg::IN_DATA_W;
    localparam int IN_USER_W  = aocc_pkg::IN_USER_W;
    localparam int OUT_DATA_W = aocc_pkg::OUT_DATA_W;
    localparam int OUT_USER_W = aocc_pkg::OUT_USER_W;
    localparam int ONE_G_W    = aocc_pkg::ONE_G_W;
    localparam int SUM_W      = aocc_pkg::SUM_W;
    localparam int CNT_W      = aocc_pkg::CNT_W;
    localparam int BIAS_W     = aocc_pkg::BIAS_W;
    localparam int ZOUT_W     = aocc_pkg::ZOUT_W;

    // one row of the directed stimulus
    typedef struct {
        logic                 op;
        logic [IN_DATA_W-1:0] raw;
        bit                   typed;
        aocc_pkg::result_t    want;
    } dir_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [ONE_G_W-1:0]    cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // model state
    logic signed [SUM_W-1:0]  acc_x = '0;
    logic signed [SUM_W-1:0]  acc_y = '0;
    logic signed [SUM_W-1:0]  acc_z = '0;
    logic [CNT_W-1:0]         cal_count = '0;
    logic signed [BIAS_W-1:0] bias_x = '0;
    logic signed [BIAS_W-1:0] bias_y = '0;
    logic signed [BIAS_W-1:0] bias_z = '0;
    logic [ONE_G_W-1:0]       one_g = aocc_pkg::ONE_G_RESET;

    aocc_pkg::result_t pending_results[$];
    dir_row_t          dir_rows[$];
    int       err_cnt     = 0;
    int       readings    = 0;
    int       burst_left  = 0;
    int       cycle_cnt   = 0;
    int       stall_mode  = 0;
    int       stall_left  = 0;
    int       stall_tick  = 0;

    accel_offset_calibrate_correct_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 clk = ~clk;

    // register word to signed 12-bit sample
    function automatic int axis_sample(input logic [15:0] w);
        return int'($signed(w)) >>> 4;
    endfunction

    function automatic aocc_pkg::result_t mk_res(input aocc_pkg::kind_t k, input int x,
                                                 input int y, input int z);
        aocc_pkg::result_t r;
        r.result_kind = k;
        r.x_value     = x[BIAS_W-1:0];
        r.y_value     = y[BIAS_W-1:0];
        r.z_value     = z[ZOUT_W-1:0];
        return r;
    endfunction

    function automatic dir_row_t mk_row(input logic op, input logic [15:0] wx,
                                        input logic [15:0] wy, input logic [15:0] wz,
                                        input bit typed, input aocc_pkg::result_t want);
        dir_row_t row;
        row.op    = op;
        row.raw   = {wz, wy, wx};
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // expected result of one reading; updates sums and offsets
    function automatic aocc_pkg::result_t predict_reading(input logic op,
                                                          input logic [IN_DATA_W-1:0] raw);
        int                ax, ay, az, g, d;
        aocc_pkg::result_t res;
        ax  = axis_sample(raw[15:0]);
        ay  = axis_sample(raw[31:16]);
        az  = axis_sample(raw[47:32]);
        res = '0;
        if (op == aocc_pkg::OP_MEASURE)
        begin
            res.result_kind = aocc_pkg::KIND_CORRECTED;
            d = ax - int'(bias_x);
            res.x_value = d[BIAS_W-1:0];
            d = ay - int'(bias_y);
            res.y_value = d[BIAS_W-1:0];
            d = az - int'(bias_z);
            res.z_value = d[ZOUT_W-1:0];
        end
        else
        begin
            acc_x     = acc_x + SUM_W'(ax);
            acc_y     = acc_y + SUM_W'(ay);
            acc_z     = acc_z + SUM_W'(az);
            cal_count = cal_count + 1'b1;
            if (cal_count >= CAL_N)
            begin
                // average truncates toward zero, gravity removed from z
                g      = int'(one_g);
                bias_x = BIAS_W'(acc_x / CAL_N);
                bias_y = BIAS_W'(acc_y / CAL_N);
                if (acc_z > 0)
                    bias_z = BIAS_W'(acc_z / CAL_N - g);
                else
                    bias_z = BIAS_W'(acc_z / CAL_N + g);
                acc_x     = '0;
                acc_y     = '0;
                acc_z     = '0;
                cal_count = '0;
                res.result_kind = aocc_pkg::KIND_CAL_DONE;
                res.x_value     = bias_x;
                res.y_value     = bias_y;
                res.z_value     = ZOUT_W'(bias_z);
            end
            else
                res.result_kind = aocc_pkg::KIND_CAL_BUSY;
        end
        return res;
    endfunction

    // one reading transfer, sender works in bursts with gaps between them
    task automatic send_reading(input logic op, input logic [IN_DATA_W-1:0] raw,
                                input bit typed, input aocc_pkg::result_t want);
        int                gap;
        aocc_pkg::result_t res;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        res = predict_reading(op, raw);
        pending_results.push_back(typed ? want : res);
        burst_left--;
        readings++;
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_one_g(input logic [ONE_G_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        one_g = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_base();
        case ($urandom_range(0, 5))
            0:       return -2048;
            1:       return 2047;
            2:       return 0;
            default: return int'($urandom_range(0, 4095)) - 2048;
        endcase
    endfunction

    function automatic int pick_spread();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            2:       return 40;
            default: return 400;
        endcase
    endfunction

    // register word around a base value, random low nibble
    function automatic logic [15:0] axis_word(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return {v[11:0], 4'($urandom_range(0, 15))};
    endfunction

    function automatic logic [IN_DATA_W-1:0] noise_raw();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // full calibration run with stray measurements mixed in
    task automatic run_calibration();
        int bx, by, bz, spx, spy, spz;
        bx  = pick_base();
        by  = pick_base();
        bz  = pick_base();
        spx = pick_spread();
        spy = pick_spread();
        spz = pick_spread();
        for (int i = 0; i < CAL_N; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_reading(aocc_pkg::OP_MEASURE, noise_raw(), 1'b0, '0);
            send_reading(aocc_pkg::OP_CALIBRATE,
                         {axis_word(bz, spz), axis_word(by, spy), axis_word(bx, spx)},
                         1'b0, '0);
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // receiver stall pattern, switches between stall modes at random
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_tick % 5 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        aocc_pkg::result_t got;
        aocc_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata, m_tuser};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, kind %0d x %0d y %0d z %0d", $time,
                         got.result_kind, got.x_value, got.y_value, got.z_value);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", int'(want.result_kind), int'(got.result_kind));
                check_field("x_value", int'(want.x_value), int'(got.x_value));
                check_field("y_value", int'(want.y_value), int'(got.y_value));
                check_field("z_value", int'(want.z_value), int'(got.z_value));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("** accel_offset_calibrate_correct_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int stop_at;
        logic [ONE_G_W-1:0] g_val;

        // directed table: extremes with zero offsets, then a flat calibration
        dir_rows.push_back(mk_row(aocc_pkg::OP_MEASURE, 16'h7FF0, 16'h8000, 16'hFFFF, 1'b1,
                                  mk_res(aocc_pkg::KIND_CORRECTED, 2047, -2048, -1)));
        dir_rows.push_back(mk_row(aocc_pkg::OP_MEASURE, 16'h000F, 16'hFFF0, 16'h7FFF, 1'b1,
                                  mk_res(aocc_pkg::KIND_CORRECTED, 0, -1, 2047)));
        dir_rows.push_back(mk_row(aocc_pkg::OP_MEASURE, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                                  mk_res(aocc_pkg::KIND_CORRECTED, 0, 0, 0)));
        dir_rows.push_back(mk_row(aocc_pkg::OP_MEASURE, 16'h8000, 16'h7FFF, 16'h800F, 1'b1,
                                  mk_res(aocc_pkg::KIND_CORRECTED, -2048, 2047, -2048)));
        for (int i = 0; i < CAL_N - 1; i++)
        begin
            dir_rows.push_back(mk_row(aocc_pkg::OP_CALIBRATE, 16'h8000, 16'h7FF0, 16'h4000,
                                      1'b1, mk_res(aocc_pkg::KIND_CAL_BUSY, 0, 0, 0)));
            // measurement in the middle of a calibration keeps the old offsets
            if (i == 9)
                dir_rows.push_back(mk_row(aocc_pkg::OP_MEASURE, 16'h1230, 16'h0000,
                                          16'h0000, 1'b1,
                                          mk_res(aocc_pkg::KIND_CORRECTED, 291, 0, 0)));
        end
        // one g of 1024 exactly cancels the z average
        dir_rows.push_back(mk_row(aocc_pkg::OP_CALIBRATE, 16'h8000, 16'h7FF0, 16'h4000, 1'b1,
                                  mk_res(aocc_pkg::KIND_CAL_DONE, -2048, 2047, 0)));
        // corrected by the new offsets
        dir_rows.push_back(mk_row(aocc_pkg::OP_MEASURE, 16'h0000, 16'hFFF0, 16'h4000, 1'b0,
                                  '0));

        // reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_reading(dir_rows[i].op, dir_rows[i].raw, dir_rows[i].typed,
                         dir_rows[i].want);

        // random phases, each with its own counts-per-g
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       g_val = '0;
                1:       g_val = '1;
                2:       g_val = 11'd1;
                default: g_val = 11'($urandom_range(0, 2047));
            endcase
            drain_results();
            write_one_g(g_val);
            stop_at = readings + PHASE_ITEMS;
            while (readings < stop_at)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        run_calibration();
                    6, 7, 8:
                        repeat ($urandom_range(5, 15))
                            send_reading(aocc_pkg::OP_MEASURE, noise_raw(), 1'b0, '0);
                    default:
                        repeat ($urandom_range(1, 10))
                            send_reading(1'($urandom_range(0, 1)), noise_raw(), 1'b0, '0);
                endcase
            end
        end

        // wind down
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("** accel_offset_calibrate_correct_core: PASSED **");
        else
            $display("** accel_offset_calibrate_correct_core: FAILED **");
        $finish;
    end

endmodule
